>>> hw/rtl/mck_pkg.sv
// ----------------------------------------------------------------------------
// mck_pkg: shared types, constants and Morse table for the character keyer
// Holds the packed Morse ROM, the character lookup and the sequencer codes.
// ----------------------------------------------------------------------------
package mck_pkg;

	localparam int DIT_W   = 16;
	localparam int LEVEL_W = 8;
	localparam int DUR_W   = 19;
	localparam int TONE_W  = 16;
	localparam int CHAR_W  = 8;
	localparam int CFG_W   = 16;
	localparam int CNT_W   = 3;
	localparam int BITS_W  = 6;
	localparam int MUL_W   = 3;
	localparam int ROM_DEPTH = 46;
	localparam int ROM_IDX_W = $clog2(ROM_DEPTH);

	localparam logic [DIT_W-1:0]   DIT_RESET   = 16'd60;
	localparam logic [LEVEL_W-1:0] LEVEL_RESET = 8'd127;

	// register indexes on the configuration port
	localparam logic REG_DIT_LENGTH = 1'b0;
	localparam logic REG_TONE_LEVEL = 1'b1;

	// dit multiples fed to the shared multiplier
	localparam logic [MUL_W-1:0] MUL_DIT     = 3'd1;
	localparam logic [MUL_W-1:0] MUL_DAH     = 3'd3;
	localparam logic [MUL_W-1:0] MUL_WORDGAP = 3'd7;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	typedef enum logic [1:0] {
		KIND_MORSE   = 2'd0,
		KIND_SILENCE = 2'd1,
		KIND_TONE    = 2'd2
	} kind_t;

	localparam logic [7:0] MORSE_ROM [ROM_DEPTH] = '{
		8'h42, 8'h81, 8'h85, 8'h61, 8'h20, 8'h84, 8'h63, 8'h80, 8'h40, 8'h8E,
		8'h65, 8'h82, 8'h43, 8'h41, 8'h67, 8'h86, 8'h8B, 8'h62, 8'h60, 8'h21,
		8'h64, 8'h88, 8'h66, 8'h89, 8'h8D, 8'h83,
		8'hAA, 8'hF3, 8'hE1, 8'hEA, 8'hA9, 8'hBF, 8'hBE, 8'hBC, 8'hB8, 8'hB0,
		8'hA0, 8'hA1, 8'hA3, 8'hA7, 8'hAF, 8'hC7, 8'hD5, 8'hB1, 8'hCC, 8'hF5
	};

	// packed code for a character, zero when it has no Morse code
	function automatic logic [7:0] morse_lookup(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0]    uc;
		logic [CHAR_W-1:0]    diff;
		logic [ROM_IDX_W-1:0] idx;
		logic                 hit;
		uc   = c;
		diff = '0;
		idx  = '0;
		hit  = 1'b1;
		if (c inside {[8'd97:8'd122]}) begin
			uc = c - 8'd32;
		end
		if (uc inside {[8'd65:8'd90]}) begin
			diff = uc - 8'd65;
			idx  = diff[ROM_IDX_W-1:0];
		end else if (uc inside {[8'd43:8'd59]}) begin
			diff = uc - 8'd17;
			idx  = diff[ROM_IDX_W-1:0];
		end else if (uc == 8'd61) begin
			idx = ROM_IDX_W'(43);
		end else if (uc == 8'd63) begin
			idx = ROM_IDX_W'(44);
		end else if (uc == 8'd33) begin
			idx = ROM_IDX_W'(45);
		end else begin
			hit = 1'b0;
		end
		return hit ? MORSE_ROM[idx] : 8'h00;
	endfunction

endpackage

>>> hw/rtl/morse_character_keyer.sv
// ----------------------------------------------------------------------------
// morse_character_keyer: turns characters or tone requests into key segments
// A small sequencer walks the Morse code of one character and drives one
// shared dit multiplier to size each segment.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) takes one request: a character to send
//   (req_type 0) or a plain tone of tone_ms milliseconds (req_type 1).
//   Output channel (out_valid/out_stall) gives key segments: key_on, level,
//   duration in ms and last on the final segment of the request.
//   A character gives 2*n segments for n elements (at most 12), a tone or an
//   unmapped character gives one. The request beat moves the sequencer into
//   its emit state and each segment is registered in the output register;
//   the sequencer emits a single segment per cycle through the shared
//   multiplier unless the receiver stalls. in_stall is high while segments
//   remain to be emitted; the next request is taken while the final segment
//   still waits. When the receiver stalls, the output register holds and the
//   sequencer waits. Reset empties the output register, returns to idle and
//   loads dit_length 60 and tone_level 127. Configuration (cfg_we, cfg_index,
//   cfg_wdata) must be written only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module morse_character_keyer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [mck_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         req_type,
	input  logic [mck_pkg::CHAR_W-1:0]   char_code,
	input  logic [mck_pkg::TONE_W-1:0]   tone_ms,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         key_on,
	output logic [mck_pkg::LEVEL_W-1:0]  level,
	output logic [mck_pkg::DUR_W-1:0]    duration,
	output logic                         last
);
	import mck_pkg::*;

	state_t              state_q;
	kind_t               kind_q;
	logic [DIT_W-1:0]    dit_q;
	logic [LEVEL_W-1:0]  tone_level_q;
	logic [TONE_W-1:0]   tone_q;
	logic [BITS_W-1:0]   bits_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                gap_q;

	logic                out_valid_q;
	logic                key_on_q;
	logic [LEVEL_W-1:0]  level_q;
	logic [DUR_W-1:0]    duration_q;
	logic                last_q;

	logic                in_beat;
	logic                adv;
	logic [7:0]          code;
	logic [MUL_W-1:0]    mul;
	logic [DUR_W-1:0]    product;
	logic                seg_on;
	logic                seg_last;
	logic                seg_tone;

	assign in_stall = (state_q != ST_IDLE);
	assign in_beat  = in_valid && !in_stall;
	assign adv      = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);
	assign code     = morse_lookup(char_code);

	// segment selection for the current step
	always_comb begin
		mul      = MUL_DIT;
		seg_on   = 1'b0;
		seg_last = 1'b0;
		seg_tone = 1'b0;
		case (kind_q)
			KIND_TONE: begin
				seg_on   = 1'b1;
				seg_last = 1'b1;
				seg_tone = 1'b1;
			end
			KIND_SILENCE: begin
				mul      = MUL_WORDGAP;
				seg_last = 1'b1;
			end
			KIND_MORSE: begin
				if (gap_q) begin
					mul = MUL_DIT;
				end else if (cnt_q != '0) begin
					seg_on = 1'b1;
					mul    = bits_q[0] ? MUL_DAH : MUL_DIT;
				end else begin
					mul      = MUL_DAH;
					seg_last = 1'b1;
				end
			end
			default: begin
				seg_last = 1'b1;
			end
		endcase
	end

	// shared dit multiplier
	assign product = {{(DUR_W-DIT_W){1'b0}}, dit_q} * {{(DUR_W-MUL_W){1'b0}}, mul};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dit_q        <= DIT_RESET;
			tone_level_q <= LEVEL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DIT_LENGTH: dit_q        <= cfg_wdata[DIT_W-1:0];
				REG_TONE_LEVEL: tone_level_q <= cfg_wdata[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q  <= KIND_MORSE;
			cnt_q   <= '0;
			gap_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						state_q <= ST_EMIT;
						gap_q   <= 1'b0;
						if (req_type) begin
							kind_q <= KIND_TONE;
						end else if (code == 8'h00) begin
							kind_q <= KIND_SILENCE;
						end else begin
							kind_q <= KIND_MORSE;
						end
						if (code[7:6] == 2'b11) begin
							cnt_q <= CNT_W'(6);
						end else begin
							cnt_q <= code[7:5];
						end
					end
				end
				ST_EMIT: begin
					if (adv) begin
						if (seg_last) begin
							state_q <= ST_IDLE;
						end else if (gap_q) begin
							gap_q <= 1'b0;
						end else begin
							cnt_q <= cnt_q - 1'b1;
							gap_q <= (cnt_q > CNT_W'(1));
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// element bits and tone length, no reset needed
	always_ff @(posedge clk) begin
		if (in_beat) begin
			tone_q <= tone_ms;
			if (code[7:6] == 2'b11) begin
				bits_q <= code[5:0];
			end else begin
				bits_q <= {1'b0, code[4:0]};
			end
		end else if (adv && !gap_q && seg_on && !seg_tone) begin
			bits_q <= bits_q >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			key_on_q   <= seg_on;
			level_q    <= seg_on ? tone_level_q : '0;
			duration_q <= seg_tone ? {{(DUR_W-TONE_W){1'b0}}, tone_q} : product;
			last_q     <= seg_last;
		end
	end

	assign out_valid = out_valid_q;
	assign key_on    = key_on_q;
	assign level     = level_q;
	assign duration  = duration_q;
	assign last      = last_q;

`ifndef SYNTHESIS
	a_beat_starts_emit: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> (state_q == ST_EMIT))
		else $error("request beat did not start emission");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (cnt_q <= CNT_W'(6)))
		else $error("element count out of range");

	a_silent_level: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !key_on) |-> (level == '0))
		else $error("nonzero level on a silent segment");

	a_gap_only_morse: assert property (@(posedge clk) disable iff (!arst_n)
		gap_q |-> (state_q == ST_EMIT) && (kind_q == KIND_MORSE))
		else $error("element gap pending outside Morse emission");
`endif

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the Morse character keyer
// Sends characters and tone requests at several dit/level settings and checks
// every key segment against an in-bench model of the Morse encoding. Both
// channels idle at random, and the output side holds off once for a long time.
// ----------------------------------------------------------------------------
module testbench;

	import mck_pkg::*;

	typedef struct packed {
		logic               on;
		logic [LEVEL_W-1:0] lvl;
		logic [DUR_W-1:0]   dur;
		logic               fin;
	} seg_t;

	typedef struct packed {
		logic              tone;
		logic [CHAR_W-1:0] ch;
		logic [TONE_W-1:0] ms;
		logic              typed;
		seg_t              seg;
	} row_t;

	localparam int N_ROWS      = 25;
	localparam int N_PHASES    = 6;
	localparam int PER_PHASE   = 72;
	localparam int HOLD_CYCLES = 300;
	localparam int LIMIT       = 400000;

	localparam seg_t NO_SEG     = '0;
	localparam seg_t WORD_SPACE = '{1'b0, 8'd0, 19'd420, 1'b1};

	// packed codes: 11zzzzzz is six elements, else bits 7:5 are the count; bit 0 first, 1 = dah
	localparam logic [7:0] CODE_TABLE [46] = '{
		8'h42, 8'h81, 8'h85, 8'h61, 8'h20, 8'h84, 8'h63, 8'h80, 8'h40, 8'h8E,
		8'h65, 8'h82, 8'h43, 8'h41, 8'h67, 8'h86, 8'h8B, 8'h62, 8'h60, 8'h21,
		8'h64, 8'h88, 8'h66, 8'h89, 8'h8D, 8'h83,
		8'hAA, 8'hF3, 8'hE1, 8'hEA, 8'hA9, 8'hBF, 8'hBE, 8'hBC, 8'hB8, 8'hB0,
		8'hA0, 8'hA1, 8'hA3, 8'hA7, 8'hAF, 8'hC7, 8'hD5, 8'hB1, 8'hCC, 8'hF5
	};

	// typed rows hold values at the reset setting: dit 60, level 127
	localparam row_t DIR_ROWS [N_ROWS] = '{
		'{1'b1, 8'hFF, 16'd0,     1'b1, '{1'b1, 8'd127, 19'd0,     1'b1}},
		'{1'b1, 8'h00, 16'hFFFF,  1'b1, '{1'b1, 8'd127, 19'd65535, 1'b1}},
		'{1'b1, 8'hAA, 16'h5555,  1'b1, '{1'b1, 8'd127, 19'd21845, 1'b1}},
		'{1'b0, 8'd0,   16'hFFFF, 1'b1, WORD_SPACE},
		'{1'b0, 8'd255, 16'd0,    1'b1, WORD_SPACE},
		'{1'b0, 8'd32,  16'd0,    1'b1, WORD_SPACE},
		'{1'b0, 8'd64,  16'd0,    1'b1, WORD_SPACE},
		'{1'b0, 8'd91,  16'd0,    1'b1, WORD_SPACE},
		'{1'b0, 8'd96,  16'd0,    1'b1, WORD_SPACE},
		'{1'b0, 8'd123, 16'd0,    1'b1, WORD_SPACE},
		'{1'b0, 8'd42,  16'd0,    1'b1, WORD_SPACE},
		'{1'b0, 8'd60,  16'd0,    1'b1, WORD_SPACE},
		'{1'b0, 8'd62,  16'd0,    1'b1, WORD_SPACE},
		'{1'b0, 8'd65,  16'd0,    1'b0, NO_SEG},
		'{1'b0, 8'd90,  16'd0,    1'b0, NO_SEG},
		'{1'b0, 8'd97,  16'd0,    1'b0, NO_SEG},
		'{1'b0, 8'd122, 16'd0,    1'b0, NO_SEG},
		'{1'b0, 8'd69,  16'd0,    1'b0, NO_SEG},
		'{1'b0, 8'd43,  16'd0,    1'b0, NO_SEG},
		'{1'b0, 8'd44,  16'd0,    1'b0, NO_SEG},
		'{1'b0, 8'd48,  16'd0,    1'b0, NO_SEG},
		'{1'b0, 8'd59,  16'd0,    1'b0, NO_SEG},
		'{1'b0, 8'd61,  16'd0,    1'b0, NO_SEG},
		'{1'b0, 8'd63,  16'd0,    1'b0, NO_SEG},
		'{1'b0, 8'd33,  16'd0,    1'b0, NO_SEG}
	};

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic                cfg_index;
	logic [CFG_W-1:0]    cfg_wdata;
	logic                in_valid;
	logic                in_stall;
	logic                req_type;
	logic [CHAR_W-1:0]   char_code;
	logic [TONE_W-1:0]   tone_ms;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                key_on;
	logic [LEVEL_W-1:0]  level;
	logic [DUR_W-1:0]    duration;
	logic                last;

	seg_t               seg_expect [$];
	logic [DIT_W-1:0]   cur_dit;
	logic [LEVEL_W-1:0] cur_level;
	logic               hold_req = 1'b0;
	logic               quiet = 1'b0;
	int                 gap_odds = 0;
	int                 n_req = 0;
	int                 n_seg = 0;
	int                 n_fail = 0;
	int                 cycles = 0;

	morse_character_keyer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.char_code (char_code),
		.tone_ms   (tone_ms),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.key_on    (key_on),
		.level     (level),
		.duration  (duration),
		.last      (last)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("%0t: timeout with %0d segments outstanding", $time, seg_expect.size());
			$display("testbench: FAIL");
			$finish;
		end
	end

	// packed code of a character, zero when it has none
	function automatic logic [7:0] code_of(input logic [CHAR_W-1:0] c);
		int u;
		u = int'(c);
		if (u >= 97 && u <= 122)
			u = u - 32;
		if (u >= 65 && u <= 90)
			return CODE_TABLE[u - 65];
		if (u >= 43 && u <= 59)
			return CODE_TABLE[u - 17];
		if (u == 61)
			return CODE_TABLE[43];
		if (u == 63)
			return CODE_TABLE[44];
		if (u == 33)
			return CODE_TABLE[45];
		return 8'h00;
	endfunction

	// queue the key segments one request should produce
	task automatic predict_keying(input logic tone, input logic [CHAR_W-1:0] ch,
			input logic [TONE_W-1:0] ms);
		logic [7:0]       code;
		logic [5:0]       bits;
		logic [DUR_W-1:0] dit;
		int               count;
		int               i;
		dit = DUR_W'(cur_dit);
		if (tone) begin
			seg_expect.push_back('{1'b1, cur_level, DUR_W'(ms), 1'b1});
			return;
		end
		code = code_of(ch);
		if (code == 8'h00) begin
			seg_expect.push_back('{1'b0, 8'd0, dit * 19'd7, 1'b1});
			return;
		end
		if (code[7:6] == 2'b11) begin
			count = 6;
			bits  = code[5:0];
		end else begin
			count = int'(code[7:5]);
			bits  = {1'b0, code[4:0]};
		end
		for (i = 0; i < count; i++) begin
			if (i > 0)
				seg_expect.push_back('{1'b0, 8'd0, dit, 1'b0});
			seg_expect.push_back('{1'b1, cur_level, bits[0] ? dit * 19'd3 : dit, 1'b0});
			bits = bits >> 1;
		end
		seg_expect.push_back('{1'b0, 8'd0, dit * 19'd3, 1'b1});
	endtask

	task automatic send_request(input logic tone, input logic [CHAR_W-1:0] ch,
			input logic [TONE_W-1:0] ms, input logic typed, input seg_t seg);
		int gap;
		if (!quiet && $urandom_range(0, 9) < gap_odds) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 12);
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		req_type  <= tone;
		char_code <= ch;
		tone_ms   <= ms;
		do @(posedge clk); while (in_stall);
		if (typed)
			seg_expect.push_back(seg);
		else
			predict_keying(tone, ch, ms);
		n_req++;
	endtask

	// mostly mapped characters, the rest random bytes and tones
	task automatic random_request();
		logic [CHAR_W-1:0] ch;
		logic [TONE_W-1:0] ms;
		int                pick;
		ch   = CHAR_W'($urandom_range(0, 255));
		ms   = TONE_W'($urandom_range(0, 65535));
		pick = $urandom_range(0, 9);
		if ($urandom_range(0, 5) == 0)
			ms = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
		if (pick <= 5) begin
			case ($urandom_range(0, 3))
				0: ch = CHAR_W'(65 + $urandom_range(0, 25));
				1: ch = CHAR_W'(97 + $urandom_range(0, 25));
				2: ch = CHAR_W'(43 + $urandom_range(0, 16));
				default: begin
					case ($urandom_range(0, 2))
						0: ch = 8'd61;
						1: ch = 8'd63;
						default: ch = 8'd33;
					endcase
				end
			endcase
		end
		send_request(pick >= 8, ch, ms, 1'b0, NO_SEG);
	endtask

	// writes happen only once every queued segment has come out
	task automatic set_config(input logic [DIT_W-1:0] dit, input logic [LEVEL_W-1:0] lvl);
		in_valid <= 1'b0;
		while (seg_expect.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_DIT_LENGTH;
		cfg_wdata <= CFG_W'(dit);
		@(posedge clk);
		cfg_index <= REG_TONE_LEVEL;
		cfg_wdata <= CFG_W'(lvl);
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_dit   = dit;
		cur_level = lvl;
	endtask

	// output side: check each beat, then pick the next stall
	always @(posedge clk) begin
		static int stall_left = 0;
		static int run_left = 0;
		static int hold_left = 0;
		static logic hold_done = 1'b0;
		seg_t got;
		seg_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{key_on, level, duration, last};
			n_seg++;
			if (seg_expect.size() == 0) begin
				n_fail++;
				$display("%0t: unexpected segment key_on=%0b level=%0d duration=%0d last=%0b",
					$time, got.on, got.lvl, got.dur, got.fin);
			end else begin
				want = seg_expect.pop_front();
				if (got !== want) begin
					n_fail++;
					$display("%0t: segment mismatch: expected key_on=%0b level=%0d duration=%0d %s",
						$time, want.on, want.lvl, want.dur, $sformatf("last=%0b", want.fin));
					$display("%0t:                   actual   key_on=%0b level=%0d duration=%0d %s",
						$time, got.on, got.lvl, got.dur, $sformatf("last=%0b", got.fin));
				end
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (hold_req && !hold_done) begin
			// long hold-off so the keyer backs up into its input
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else if (quiet) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (run_left > 0) begin
			run_left--;
			out_stall <= 1'b0;
		end else if ($urandom_range(0, 2) == 0) begin
			stall_left = $urandom_range(0, 11);
			out_stall <= 1'b1;
		end else begin
			run_left = $urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(20, 60);
			out_stall <= 1'b0;
		end
	end

	initial begin
		int k;
		int p;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_DIT_LENGTH;
		cfg_wdata = '0;
		in_valid  = 1'b0;
		req_type  = 1'b0;
		char_code = '0;
		tone_ms   = '0;
		cur_dit   = DIT_RESET;
		cur_level = LEVEL_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_odds = 3;
		for (k = 0; k < N_ROWS; k++)
			send_request(DIR_ROWS[k].tone, DIR_ROWS[k].ch, DIR_ROWS[k].ms,
				DIR_ROWS[k].typed, DIR_ROWS[k].seg);

		for (p = 0; p < N_PHASES; p++) begin
			case (p)
				0: set_config(16'd1, 8'd255);
				1: set_config(16'hFFFF, 8'd0);
				2: set_config(16'd0, 8'd200);
				3: set_config(DIT_W'($urandom_range(0, 65535)), LEVEL_W'($urandom_range(0, 255)));
				4: set_config(DIT_W'($urandom_range(1, 40)), LEVEL_W'($urandom_range(0, 255)));
				default: set_config(DIT_RESET, LEVEL_RESET);
			endcase
			if (p == 1)
				hold_req <= 1'b1;
			if (p == N_PHASES - 1)
				quiet <= 1'b1;
			gap_odds = (p * 3) % 7;
			repeat (PER_PHASE) random_request();
		end

		in_valid <= 1'b0;
		while (seg_expect.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);

		$display("covered %0d requests (characters, unmapped codes, tones) over %0d settings",
			n_req, N_PHASES + 1);
		$display("checked %0d key segments, %0d mismatches", n_seg, n_fail);
		if (n_fail == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

>>> morse_character_keyer.f
hw/rtl/mck_pkg.sv
hw/rtl/morse_character_keyer.sv
test/testbench.sv
